// ----- hdl/prsf_pkg.sv -----
// Shared types and constants for the pot reading stability filter.
`timescale 1ns / 1ps
`default_nettype none

package prsf_pkg;

  // Field widths.
  localparam int unsigned SAMPLE_W  = 10;
  localparam int unsigned PERIOD_W  = 8;
  localparam int unsigned ELAPSED_W = 9;

  // Configuration port.
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_PERIOD = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNLOG_ENABLE  = 1'd1;

  localparam logic [PERIOD_W-1:0]  SAMPLE_PERIOD_RST = 8'd10;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX       = 9'd511;
  localparam logic [SAMPLE_W-1:0]  CHANGE_THRESHOLD  = 10'd2;

  // Un-log map: two linear segments split between 150 and 151.
  localparam int unsigned NUM_W   = 19;
  localparam int unsigned RECIP_W = 25;
  localparam int unsigned RECIP_SHIFT = 32;
  localparam int unsigned PROD_W  = NUM_W + RECIP_W;
  localparam int unsigned QUOT_W  = 10;
  localparam logic [SAMPLE_W-1:0] SEG_LO_LAST  = 10'd150;
  localparam logic [SAMPLE_W-1:0] SEG_HI_FIRST = 10'd151;
  localparam logic [SAMPLE_W-1:0] SEG_SLOPE    = 10'd511;
  localparam logic [SAMPLE_W-1:0] SEG_HI_BASE  = 10'd512;
  localparam logic [SAMPLE_W-1:0] DIV_LO       = 10'd150;
  localparam logic [SAMPLE_W-1:0] DIV_HI       = 10'd872;
  // floor(2^32 / divisor); the estimate is low by at most one.
  localparam logic [RECIP_W-1:0] RECIP_LO = 25'd28633115;
  localparam logic [RECIP_W-1:0] RECIP_HI = 25'd4925421;

  // Request into the un-log unit.
  typedef struct packed {
    logic                start;
    logic                enable;
    logic [SAMPLE_W-1:0] value;
  } unlog_req_t;

  // Response from the un-log unit.
  typedef struct packed {
    logic                done;
    logic [SAMPLE_W-1:0] value;
  } unlog_rsp_t;

endpackage

`default_nettype wire

// ----- hdl/prsf_cell.sv -----
// One cell of the reading history chain: holds a reading and compares its input.
`timescale 1ns / 1ps
`default_nettype none

module prsf_cell (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          shift,
  input  wire logic [prsf_pkg::SAMPLE_W-1:0] data_in,
  input  wire logic [prsf_pkg::SAMPLE_W-1:0] probe,
  output logic      [prsf_pkg::SAMPLE_W-1:0] data_out,
  output logic                               match
);

  logic [prsf_pkg::SAMPLE_W-1:0] reading;

  // The reading moves one cell down the chain on every taken sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      reading <= '0;
    end else if (shift) begin
      reading <= data_in;
    end
  end

  // The value this cell will hold after the shift, checked against the new sample.
  assign match    = (data_in == probe);
  assign data_out = reading;

endmodule

`default_nettype wire

// ----- hdl/prsf_unlog.sv -----
// Three-stage un-log map with division by constants through reciprocals.
`timescale 1ns / 1ps
`default_nettype none

module prsf_unlog (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire prsf_pkg::unlog_req_t req,
  output prsf_pkg::unlog_rsp_t      rsp
);

  logic                                s1_vld;
  logic                                s1_en;
  logic [prsf_pkg::SAMPLE_W-1:0]       s1_val;
  logic                                s2_vld;
  logic                                s2_en;
  logic                                s2_hi;
  logic [prsf_pkg::SAMPLE_W-1:0]       s2_val;
  logic [prsf_pkg::NUM_W-1:0]          s2_num;
  logic                                s3_vld;
  logic                                s3_en;
  logic                                s3_hi;
  logic [prsf_pkg::SAMPLE_W-1:0]       s3_val;
  logic [prsf_pkg::NUM_W-1:0]          s3_num;
  logic [prsf_pkg::PROD_W-1:0]         s3_prod;
  logic                                done;
  logic [prsf_pkg::SAMPLE_W-1:0]       result;

  logic                                seg_hi;
  logic [prsf_pkg::SAMPLE_W-1:0]       seg_base;
  logic [prsf_pkg::NUM_W-1:0]          num_next;
  logic [prsf_pkg::QUOT_W-1:0]         q_est;
  logic [prsf_pkg::NUM_W:0]            q_times_d;
  logic [prsf_pkg::NUM_W:0]            rem;
  logic [prsf_pkg::SAMPLE_W-1:0]       divisor;
  logic [prsf_pkg::QUOT_W-1:0]         quot;
  logic [prsf_pkg::SAMPLE_W-1:0]       mapped;

  // Stage one: pick the segment and form the numerator.
  always_comb begin
    seg_hi   = (s1_val > prsf_pkg::SEG_LO_LAST);
    seg_base = seg_hi ? (s1_val - prsf_pkg::SEG_HI_FIRST) : s1_val;
    num_next = prsf_pkg::NUM_W'(seg_base * prsf_pkg::SEG_SLOPE);
  end

  // Stage three: correct the reciprocal estimate by one step and add the offset.
  always_comb begin
    divisor   = s3_hi ? prsf_pkg::DIV_HI : prsf_pkg::DIV_LO;
    q_est     = s3_prod[prsf_pkg::RECIP_SHIFT +: prsf_pkg::QUOT_W];
    q_times_d = (prsf_pkg::NUM_W+1)'(q_est * divisor);
    rem       = {1'b0, s3_num} - q_times_d;
    quot      = (rem >= {{(prsf_pkg::NUM_W+1-prsf_pkg::SAMPLE_W){1'b0}}, divisor})
                ? (q_est + 1'b1) : q_est;
    mapped    = s3_hi ? (quot + prsf_pkg::SEG_HI_BASE) : quot;
  end

  // Stage valid flags; done holds until the next start.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      s1_vld <= req.start;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      if (req.start) begin
        done <= 1'b0;
      end else if (s3_vld) begin
        done <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (req.start) begin
      s1_en  <= req.enable;
      s1_val <= req.value;
    end
    if (s1_vld) begin
      s2_en  <= s1_en;
      s2_hi  <= seg_hi;
      s2_val <= s1_val;
      s2_num <= num_next;
    end
    if (s2_vld) begin
      s3_en   <= s2_en;
      s3_hi   <= s2_hi;
      s3_val  <= s2_val;
      s3_num  <= s2_num;
      s3_prod <= s2_num * (s2_hi ? prsf_pkg::RECIP_HI : prsf_pkg::RECIP_LO);
    end
    if (s3_vld) begin
      result <= s3_en ? mapped : s3_val;
    end
  end

  assign rsp.done  = done;
  assign rsp.value = result;

endmodule

`default_nettype wire

// ----- hdl/pot_reading_stability_filter_core.sv -----
// Top level of the pot reading stability filter.
`timescale 1ns / 1ps
`default_nettype none

// Each input transfer is one millisecond tick carrying a 10-bit converter sample.
// A saturating elapsed counter decides whether the sample is taken; a taken sample
// shifts into a chain of HISTORY_DEPTH cells, and the stable value follows it when
// the difference exceeds 2, or when it differs and the whole history holds it.
// Every tick gives exactly one result. The block takes no new tick until the result
// of the last one is loaded: the tick is taken, the reported value passes the three
// stages of the un-log divider, and the result is loaded into the output register
// once it is free. A new tick is taken while a finished result still waits in the
// output register. Configuration writes are always ready and take effect at once.
module pot_reading_stability_filter_core #(
  parameter int unsigned HISTORY_DEPTH = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // Tick channel.
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [prsf_pkg::SAMPLE_W-1:0]      adc_sample,
  // Result channel.
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    sampled,
  output logic                                    changed,
  output logic      [prsf_pkg::SAMPLE_W-1:0]      stable_value,
  output logic      [prsf_pkg::SAMPLE_W-1:0]      reported_value,
  // Configuration write channel.
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [prsf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [prsf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  typedef enum logic {
    S_IDLE,
    S_BUSY
  } state_t;

  state_t                              state;
  logic [prsf_pkg::PERIOD_W-1:0]       sample_period;
  logic                                unlog_enable;
  logic [prsf_pkg::ELAPSED_W-1:0]      elapsed_ms;
  logic [prsf_pkg::SAMPLE_W-1:0]       accepted_value;
  logic                                res_sampled;
  logic                                res_changed;

  logic                                in_xfer;
  logic                                out_xfer;
  logic                                out_free;
  logic                                out_load;
  logic [prsf_pkg::ELAPSED_W-1:0]      elapsed_inc;
  logic                                take;
  logic [prsf_pkg::SAMPLE_W-1:0]       abs_diff;
  logic                                ring_equal;
  logic                                replace;
  logic [prsf_pkg::SAMPLE_W-1:0]       accepted_next;
  logic [HISTORY_DEPTH-1:0]            cell_match;
  logic [prsf_pkg::SAMPLE_W-1:0]       readings [HISTORY_DEPTH-1:0];
  prsf_pkg::unlog_req_t                ul_req;
  prsf_pkg::unlog_rsp_t                ul_rsp;

  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid && !out_stall;
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = (state == S_BUSY) && ul_rsp.done && out_free;
  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period <= prsf_pkg::SAMPLE_PERIOD_RST;
      unlog_enable  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        prsf_pkg::CFG_SAMPLE_PERIOD: sample_period <= cfg_data;
        prsf_pkg::CFG_UNLOG_ENABLE:  unlog_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // History chain: cell zero takes the sample, each cell hands its reading on.
  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
    logic [prsf_pkg::SAMPLE_W-1:0] cell_in;
    if (i == 0) begin : g_head
      assign cell_in = adc_sample;
    end else begin : g_body
      assign cell_in = readings[i-1];
    end
    prsf_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (in_xfer && take),
      .data_in  (cell_in),
      .probe    (adc_sample),
      .data_out (readings[i]),
      .match    (cell_match[i])
    );
  end

  // Tick decision: saturating counter, difference and history check.
  always_comb begin
    elapsed_inc   = (elapsed_ms == prsf_pkg::ELAPSED_MAX) ? elapsed_ms
                    : (elapsed_ms + 1'b1);
    take          = (elapsed_inc > {1'b0, sample_period});
    abs_diff      = (adc_sample >= accepted_value) ? (adc_sample - accepted_value)
                    : (accepted_value - adc_sample);
    ring_equal    = &cell_match;
    replace       = take && ((abs_diff > prsf_pkg::CHANGE_THRESHOLD) ||
                    ((adc_sample != accepted_value) && ring_equal));
    accepted_next = replace ? adc_sample : accepted_value;
  end

  // Un-log unit starts on every tick with the new stable value.
  assign ul_req.start  = in_xfer;
  assign ul_req.enable = unlog_enable;
  assign ul_req.value  = accepted_next;

  prsf_unlog u_unlog (
    .clk (clk),
    .rst (rst),
    .req (ul_req),
    .rsp (ul_rsp)
  );

  // Control state and filter state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      elapsed_ms     <= '0;
      accepted_value <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_xfer) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            elapsed_ms     <= take ? '0 : elapsed_inc;
            accepted_value <= accepted_next;
            res_sampled    <= take;
            res_changed    <= replace;
            state          <= S_BUSY;
          end
        end
        S_BUSY: begin
          if (out_load) begin
            sampled        <= res_sampled;
            changed        <= res_changed;
            stable_value   <= accepted_value;
            reported_value <= ul_rsp.value;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A change is only ever reported together with a taken sample.
  a_changed_needs_sample: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!changed || sampled))
    else $error("changed reported without a taken sample");

  // The stable value moves only on an input transfer.
  a_stable_holds: assert property (@(posedge clk) disable iff (rst)
    !in_xfer |=> $stable(accepted_value))
    else $error("stable value moved without an input transfer");

  // With the map off, the reported value is the stable value.
  a_plain_report: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !unlog_enable) |-> (reported_value == stable_value))
    else $error("reported value differs from stable value with map off");

endmodule

`default_nettype wire

// ----- tb/stability_filter_checker.sv -----
// Checker for the pot reading stability filter: predicts each tick's result and compares.
`timescale 1ns / 1ps

module stability_filter_checker
  import prsf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [SAMPLE_W-1:0]    adc_sample,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic                   sampled,
  input  logic                   changed,
  input  logic [SAMPLE_W-1:0]    stable_value,
  input  logic [SAMPLE_W-1:0]    reported_value,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatch_count,
  output int                     results_pending
);

  localparam int unsigned RING_DEPTH = 8;
  localparam int unsigned ELAPSED_CAP = 511;
  localparam int unsigned JITTER_BAND = 2;

  typedef struct packed {
    logic                sampled;
    logic                changed;
    logic [SAMPLE_W-1:0] stable;
    logic [SAMPLE_W-1:0] reported;
  } tick_result_t;

  // Shadow copy of the filter state and its settings.
  logic [SAMPLE_W-1:0] readings [RING_DEPTH];
  int unsigned         head_slot;
  logic [SAMPLE_W-1:0] held_level;
  int unsigned         ms_since_reading;
  int unsigned         period_ms;
  logic                unlog_on;

  tick_result_t expected_results [$];
  int           error_total;

  // Two-segment linear map that undoes the pot's log taper.
  function automatic logic [SAMPLE_W-1:0] unlog_level(input logic [SAMPLE_W-1:0] level);
    int unsigned x;
    x = level;
    if (x <= 150) begin
      return SAMPLE_W'((x * 511) / 150);
    end
    return SAMPLE_W'(((x - 151) * 511) / 872 + 512);
  endfunction

  task automatic clear_state();
    for (int i = 0; i < RING_DEPTH; i++) begin
      readings[i] = '0;
    end
    head_slot = RING_DEPTH - 1;
    held_level = '0;
    ms_since_reading = 0;
    period_ms = 10;
    unlog_on = 1'b0;
  endtask

  // Advances the shadow filter by one millisecond tick.
  task automatic filter_tick(input logic [SAMPLE_W-1:0] level, output tick_result_t res);
    int unsigned gap;
    logic        ring_uniform;
    res = '0;
    if (ms_since_reading < ELAPSED_CAP) begin
      ms_since_reading++;
    end
    if (ms_since_reading > period_ms) begin
      res.sampled = 1'b1;
      ms_since_reading = 0;
      head_slot = (head_slot + 1) % RING_DEPTH;
      readings[head_slot] = level;
      gap = (level >= held_level) ? level - held_level : held_level - level;
      ring_uniform = 1'b1;
      for (int i = 0; i < RING_DEPTH; i++) begin
        if (readings[i] != level) begin
          ring_uniform = 1'b0;
        end
      end
      // Large moves follow at once; small ones only once the whole ring agrees.
      if (gap > JITTER_BAND || (level != held_level && ring_uniform)) begin
        held_level = level;
        res.changed = 1'b1;
      end
    end
    res.stable = held_level;
    res.reported = unlog_on ? unlog_level(held_level) : held_level;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      error_total++;
      $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endtask

  initial begin
    clear_state();
    error_total = 0;
    mismatch_count = 0;
    results_pending = 0;
  end

  // Watch all three channels at each edge; outputs are checked before the new tick
  // is queued, since a tick cannot produce its result in the cycle it is taken.
  always @(posedge clk) begin : watch
    tick_result_t due;
    tick_result_t fresh;
    if (rst) begin
      clear_state();
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          error_total++;
          $error("result transfer with no tick outstanding");
        end else begin
          due = expected_results.pop_front();
          check_field("sampled", due.sampled, sampled);
          check_field("changed", due.changed, changed);
          check_field("stable_value", due.stable, stable_value);
          check_field("reported_value", due.reported, reported_value);
        end
      end
      if (in_valid && !in_stall) begin
        filter_tick(adc_sample, fresh);
        expected_results.push_back(fresh);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SAMPLE_PERIOD: begin
            period_ms = cfg_data;
          end
          CFG_UNLOG_ENABLE: begin
            unlog_on = cfg_data[0];
          end
          default: begin
          end
        endcase
      end
    end
    mismatch_count <= error_total;
    results_pending <= expected_results.size();
  end

endmodule

// ----- tb/pot_reading_stability_filter_core_test.sv -----
// Top of the testbench for the pot reading stability filter: stimulus and verdict.
`timescale 1ns / 1ps

module pot_reading_stability_filter_core_test;
  import prsf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned IDLE_PERCENT = 18;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned PRESSURE_CYCLES = 300;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [SAMPLE_W-1:0]    adc_sample = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   sampled;
  logic                   changed;
  logic [SAMPLE_W-1:0]    stable_value;
  logic [SAMPLE_W-1:0]    reported_value;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int                     mismatch_count;
  int                     results_pending;
  int unsigned            cycle_count = 0;
  int                     ticks_sent = 0;
  logic                   steady_flow = 1'b0;
  logic                   hold_off = 1'b0;
  logic [SAMPLE_W-1:0]    pot_level = '0;
  int                     repeat_left = 0;

  pot_reading_stability_filter_core uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .adc_sample     (adc_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .sampled        (sampled),
    .changed        (changed),
    .stable_value   (stable_value),
    .reported_value (reported_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  stability_filter_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .adc_sample      (adc_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .sampled         (sampled),
    .changed         (changed),
    .stable_value    (stable_value),
    .reported_value  (reported_value),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** pot_reading_stability_filter_core: FAILED **");
      $finish;
    end
  end

  // Result side: random stalls, none during the steady stretch, solid during hold-off.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_off || (!steady_flow && ($urandom_range(99) < IDLE_PERCENT));
    end
  end

  // One long hold-off on the result side while ticks keep coming, so the block backs up.
  initial begin
    wait (ticks_sent >= 450);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (PRESSURE_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Offers one tick, with random idle cycles ahead of it, and returns at its transfer.
  task automatic send_tick(input logic [SAMPLE_W-1:0] level);
    while (!steady_flow && ($urandom_range(99) < IDLE_PERCENT)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    adc_sample <= level;
    do @(posedge clk); while (in_stall);
    ticks_sent++;
  endtask

  // Picks a level near the current one, clipped to the converter range.
  function automatic logic [SAMPLE_W-1:0] nearby_level(input logic [SAMPLE_W-1:0] level);
    int t;
    t = int'(level) + int'($urandom_range(6)) - 3;
    if (t < 0) begin
      t = 0;
    end else if (t > 1023) begin
      t = 1023;
    end
    return SAMPLE_W'(t);
  endfunction

  // Mostly a pot that jitters around a level and dwells on it; some full-range noise.
  task automatic send_random_ticks(input int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      if (repeat_left > 0) begin
        repeat_left--;
      end else begin
        pick = $urandom_range(99);
        if (pick < 30) begin
          pot_level = SAMPLE_W'($urandom_range(1023));
        end else begin
          pot_level = nearby_level(pot_level);
          if (pick >= 65) begin
            repeat_left = $urandom_range(11, 7);
          end
        end
      end
      send_tick(pot_level);
    end
  endtask

  // Lets every outstanding result come out, then lets the pipeline settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both registers back to back; only called while the block is idle.
  task automatic write_registers(input logic [CFG_DATA_W-1:0] period,
                                 input logic [CFG_DATA_W-1:0] unlog_bits);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_SAMPLE_PERIOD;
    cfg_data <= period;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_UNLOG_ENABLE;
    cfg_data <= unlog_bits;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: ten ticks without a reading, the eleventh takes one.
    send_tick(10'd1023);
    send_tick(10'd0);
    send_tick(10'd512);
    send_tick(10'd511);
    send_tick(10'd341);
    send_tick(10'd682);
    send_tick(10'd1);
    send_tick(10'd1022);
    send_tick(10'd2);
    send_tick(10'd1020);
    send_tick(10'd1023);
    drain_results();

    // Reading on every tick with the un-log map on; upper data bits are don't-care.
    write_registers(8'd0, 8'h81);
    send_tick(10'd0);
    send_tick(10'd1023);
    send_tick(10'd1022);
    send_tick(10'd1021);
    // A small step is taken only once the whole ring holds it.
    repeat (8) send_tick(10'd1022);
    // Both sides of the un-log knee.
    send_tick(10'd150);
    send_tick(10'd151);
    send_tick(10'd0);
    send_tick(10'd151);
    send_tick(10'd148);
    send_tick(10'd1);
    drain_results();

    write_registers(8'd0, 8'hFE);
    send_random_ticks(300);
    drain_results();

    // No idling on either side here; the long hold-off falls in this phase.
    steady_flow <= 1'b1;
    write_registers(8'd1, 8'h01);
    send_random_ticks(300);
    drain_results();
    steady_flow <= 1'b0;

    write_registers(8'd255, 8'h7F);
    send_random_ticks(300);
    drain_results();

    write_registers(CFG_DATA_W'($urandom_range(40, 2)), CFG_DATA_W'($urandom_range(255)));
    send_random_ticks(350);
    drain_results();

    if (mismatch_count == 0) begin
      $display("** pot_reading_stability_filter_core: PASSED **");
    end else begin
      $display("** pot_reading_stability_filter_core: FAILED **");
    end
    $finish;
  end

endmodule
